// ----- src/fsc_pkg.sv -----
`timescale 1ns / 1ps
// shared constants and types of the frustum sphere cull unit
package fsc_pkg;

  localparam int FRACTION_BITS = 16;

  localparam int NPLANE = 6;
  localparam int NREG   = 8;
  localparam int IDXW   = 3;
  localparam int REGW   = 64;
  localparam int WORDW  = 32;
  localparam int CTRW   = 32;
  localparam int RADW   = 31;

  // plane coefficient, sum or difference of two matrix words
  localparam int CW  = WORDW + 1;
  // one coefficient times one centre coordinate
  localparam int PW  = CW + CTRW;
  // constant term scaled to the centre's fixed point
  localparam int DW  = CW + FRACTION_BITS;
  // signed plane distance
  localparam int SW  = ((PW > DW) ? PW : DW) + 2;
  localparam int MW  = SW - 1;
  localparam int MLO = MW / 2;
  localparam int MHI = MW - MLO;
  localparam int SSW = 2 * MW;

  // squared normal length
  localparam int SQW = 2 * WORDW + 1;
  localparam int NW  = SQW + 1;
  localparam int NLO = NW / 2;
  localparam int NHI = NW - NLO;

  // squared radius and its product with the squared normal length
  localparam int R2W = 2 * RADW;
  localparam int RLO = R2W / 2;
  localparam int RHI = R2W - RLO;
  localparam int RNW = R2W + NW;

  localparam int PLW = 3;

  typedef logic signed [CW-1:0] coef_t;
  // index 0..2 are the normal, index 3 the constant term
  typedef coef_t [3:0] plane_coef_t;

  typedef enum logic [PLW-1:0] {
    PL_LEFT,
    PL_RIGHT,
    PL_BOTTOM,
    PL_TOP,
    PL_NEAR,
    PL_FAR,
    PL_NONE
  } plane_code_t;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } stage_en_t;

endpackage

// ----- src/fsc_coef.sv -----
`timescale 1ns / 1ps
// matrix registers and the plane coefficients derived from them
module fsc_coef (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       cfg_write,
  input  logic [fsc_pkg::IDXW-1:0]                   cfg_index,
  input  logic [fsc_pkg::REGW-1:0]                   cfg_data,
  output fsc_pkg::plane_coef_t [fsc_pkg::NPLANE-1:0] coef,
  output logic [fsc_pkg::NPLANE-1:0][fsc_pkg::NW-1:0] nn,
  output logic [fsc_pkg::NPLANE-1:0]                 nn_nonzero
);
  import fsc_pkg::*;

  logic [REGW-1:0] mreg [NREG];
  plane_coef_t [NPLANE-1:0] coef_next;
  logic [NPLANE-1:0][2:0][SQW-1:0] sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NREG; i++) begin
        mreg[i] <= '0;
      end
    end else if (cfg_write) begin
      mreg[cfg_index] <= cfg_data;
    end
  end

  // row 3 plus or minus row k, k = plane / 2
  always_comb begin
    logic signed [CW-1:0] base;
    logic signed [CW-1:0] term;
    base = '0;
    term = '0;
    for (int p = 0; p < NPLANE; p++) begin
      for (int c = 0; c < 4; c++) begin
        base = CW'($signed(mreg[2 * c + 1][WORDW +: WORDW]));
        term = CW'($signed(mreg[2 * c + ((p >> 1) >> 1)][((p >> 1) & 1) * WORDW +: WORDW]));
        if ((p & 1) != 0) begin
          coef_next[p][c] = base - term;
        end else begin
          coef_next[p][c] = base + term;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    coef <= coef_next;
    for (int p = 0; p < NPLANE; p++) begin
      for (int c = 0; c < 3; c++) begin
        sq[p][c] <= SQW'($signed(coef[p][c]) * $signed(coef[p][c]));
      end
      nn[p] <= NW'(sq[p][0]) + NW'(sq[p][1]) + NW'(sq[p][2]);
    end
  end

  always_comb begin
    for (int p = 0; p < NPLANE; p++) begin
      nn_nonzero[p] = |nn[p];
    end
  end

endmodule

// ----- src/fsc_lane.sv -----
`timescale 1ns / 1ps
// one plane of the sphere test: distance, squares and compare
module fsc_lane (
  input  logic                               clk,
  input  fsc_pkg::stage_en_t                 en,
  input  logic [2:0][fsc_pkg::CTRW-1:0]      ctr,
  input  fsc_pkg::plane_coef_t               coef,
  input  logic [fsc_pkg::R2W-1:0]            r2,
  input  logic [fsc_pkg::NW-1:0]             nn,
  input  logic                               nn_nonzero,
  output logic                               cull
);
  import fsc_pkg::*;

  logic signed [2:0][PW-1:0] prod;
  logic signed [SW-1:0]      dterm;
  logic signed [SW-1:0]      sdist;
  logic                      neg4;
  logic                      neg5;
  logic                      neg6;
  logic [MW-1:0]             mag;
  logic [RLO+NLO-1:0]        rp_ll;
  logic [RLO+NHI-1:0]        rp_lh;
  logic [RHI+NLO-1:0]        rp_hl;
  logic [RHI+NHI-1:0]        rp_hh;
  logic [RNW-1:0]            rn5;
  logic [RNW-1:0]            rn6;
  logic [2*MLO-1:0]          q_ll;
  logic [MHI+MLO-1:0]        q_hl;
  logic [2*MHI-1:0]          q_hh;
  logic [SSW-1:0]            ss;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      for (int c = 0; c < 3; c++) begin
        prod[c] <= PW'($signed(coef[c]) * $signed(ctr[c]));
      end
      dterm <= SW'($signed(coef[3])) <<< FRACTION_BITS;
    end
    if (en.s3) begin
      sdist <= SW'($signed(prod[0])) + SW'($signed(prod[1])) + SW'($signed(prod[2])) + dterm;
    end
    if (en.s4) begin
      neg4  <= sdist[SW-1];
      mag   <= sdist[SW-1] ? MW'(-sdist) : MW'(sdist);
      rp_ll <= r2[RLO-1:0] * nn[NLO-1:0];
      rp_lh <= r2[RLO-1:0] * nn[NW-1:NLO];
      rp_hl <= r2[R2W-1:RLO] * nn[NLO-1:0];
      rp_hh <= r2[R2W-1:RLO] * nn[NW-1:NLO];
    end
    if (en.s5) begin
      neg5 <= neg4;
      rn5  <= (RNW'(rp_hh) << (RLO + NLO)) + (RNW'(rp_hl) << RLO)
            + (RNW'(rp_lh) << NLO) + RNW'(rp_ll);
      q_ll <= mag[MLO-1:0] * mag[MLO-1:0];
      q_hl <= mag[MW-1:MLO] * mag[MLO-1:0];
      q_hh <= mag[MW-1:MLO] * mag[MW-1:MLO];
    end
    if (en.s6) begin
      neg6 <= neg5;
      rn6  <= rn5;
      ss   <= (SSW'(q_hh) << (2 * MLO)) + (SSW'(q_hl) << (MLO + 1)) + SSW'(q_ll);
    end
  end

  assign cull = neg6 && nn_nonzero && (ss > SSW'(rn6));

endmodule

// ----- src/frustum_sphere_cull_unit.sv -----
`timescale 1ns / 1ps
// top level of the frustum sphere cull unit
//
// Tests one bounding sphere per word against the six planes of the view
// frustum taken from a view-projection matrix held in eight 64-bit registers.
// Input channel: in_valid/in_stall with centre_x, centre_y, centre_z and
// sphere_radius. Output channel: out_valid/out_stall with inside_res and
// culling_plane (first culling plane, or 6 when the sphere is inside).
// Matrix registers are written over cfg_write/cfg_index/cfg_data; the user
// must write them only while the unit holds no words, as the unit itself
// does not enforce it. A word may follow the write in the next cycle.
// Throughput: one word per cycle through a seven-stage pipeline, while the
// receiver does not stall. Reset clears every valid bit and all matrix
// registers to zero.
// When the receiver stalls, the output word holds; bubbles in the pipeline
// still close up, and in_stall rises only once every stage holds a word.
module frustum_sphere_cull_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [fsc_pkg::IDXW-1:0]          cfg_index,
  input  logic [fsc_pkg::REGW-1:0]          cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [fsc_pkg::CTRW-1:0]   centre_x,
  input  logic signed [fsc_pkg::CTRW-1:0]   centre_y,
  input  logic signed [fsc_pkg::CTRW-1:0]   centre_z,
  input  logic [fsc_pkg::RADW-1:0]          sphere_radius,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              inside_res,
  output logic [fsc_pkg::PLW-1:0]           culling_plane
);
  import fsc_pkg::*;

  plane_coef_t [NPLANE-1:0]     coef;
  logic [NPLANE-1:0][NW-1:0]    nn;
  logic [NPLANE-1:0]            nn_nonzero;

  logic [7:1]                   v;
  logic [7:1]                   go;
  stage_en_t                    en;

  logic [2:0][CTRW-1:0]         ctr;
  logic [RADW-1:0]              rad;
  logic [R2W-1:0]               r2_p2;
  logic [R2W-1:0]               r2_p3;
  logic [NPLANE-1:0]            cull;
  plane_code_t                  plane_next;
  plane_code_t                  plane;
  logic                         all_in;

  fsc_coef u_coef (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .coef       (coef),
    .nn         (nn),
    .nn_nonzero (nn_nonzero)
  );

  // a stage takes a new word when it is empty or its word moves on
  always_comb begin
    go[7] = !v[7] || !out_stall;
    for (int i = 6; i >= 1; i--) begin
      go[i] = !v[i] || go[i+1];
    end
  end

  assign in_stall = !go[1];
  assign en = '{s2: go[2], s3: go[3], s4: go[4], s5: go[5], s6: go[6]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (go[1]) begin
        v[1] <= in_valid;
      end
      for (int i = 2; i <= 7; i++) begin
        if (go[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go[1]) begin
      ctr <= {centre_z, centre_y, centre_x};
      rad <= sphere_radius;
    end
    if (go[2]) begin
      r2_p2 <= rad * rad;
    end
    if (go[3]) begin
      r2_p3 <= r2_p2;
    end
  end

  for (genvar p = 0; p < NPLANE; p++) begin : g_lane
    fsc_lane u_lane (
      .clk        (clk),
      .en         (en),
      .ctr        (ctr),
      .coef       (coef[p]),
      .r2         (r2_p3),
      .nn         (nn[p]),
      .nn_nonzero (nn_nonzero[p]),
      .cull       (cull[p])
    );
  end

  // lowest culling plane wins
  always_comb begin
    plane_next = PL_NONE;
    for (int p = NPLANE - 1; p >= 0; p--) begin
      if (cull[p]) begin
        plane_next = plane_code_t'(PLW'(p));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go[7]) begin
      all_in <= !(|cull);
      plane  <= plane_next;
    end
  end

  assign out_valid     = v[7];
  assign inside_res    = all_in;
  assign culling_plane = plane;

endmodule

// ----- bench/tb_frustum_sphere_cull_unit.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the frustum sphere cull unit with its own plane test model
module tb_frustum_sphere_cull_unit;
  import fsc_pkg::*;

  localparam int LATENCY     = 6;
  localparam int STUCK_LIMIT = 4000;
  localparam int WIDE        = 256;
  localparam int U           = 1 << FRACTION_BITS;

  localparam logic signed [CTRW-1:0] C_MIN = {1'b1, {(CTRW-1){1'b0}}};
  localparam logic signed [CTRW-1:0] C_MAX = {1'b0, {(CTRW-1){1'b1}}};
  localparam logic [RADW-1:0]        R_MAX = '1;

  typedef struct packed {
    logic signed [CTRW-1:0] x;
    logic signed [CTRW-1:0] y;
    logic signed [CTRW-1:0] z;
    logic [RADW-1:0]        r;
  } sphere_t;

  typedef struct packed {
    logic        all_in;
    plane_code_t plane;
  } verdict_t;

  typedef logic [REGW-1:0] reg_set_t [NREG];
  typedef logic [WORDW-1:0] word_grid_t [4][4];

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [IDXW-1:0]        cfg_index = '0;
  logic [REGW-1:0]        cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic signed [CTRW-1:0] centre_x = '0;
  logic signed [CTRW-1:0] centre_y = '0;
  logic signed [CTRW-1:0] centre_z = '0;
  logic [RADW-1:0]        sphere_radius = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   inside_res;
  logic [PLW-1:0]         culling_plane;

  logic [REGW-1:0] mat_regs [NREG] = '{default: '0};
  sphere_t         pending [$];
  verdict_t        expected [$];
  bit              in_took;
  bit              calm;
  int              errors;
  int              n_results;
  int              n_settings = 1;
  int              stuck;
  int              plane_hits [NPLANE+1];

  frustum_sphere_cull_unit dut (.*);

  always #1 clk = ~clk;

  function automatic logic signed [WIDE-1:0] mat_word(int col, int row);
    logic [REGW-1:0] r;
    r = mat_regs[2*col + row/2];
    if (row % 2) return WIDE'($signed(r[REGW-1:WORDW]));
    return WIDE'($signed(r[WORDW-1:0]));
  endfunction

  // exact plane distances, no normalization: reach^2 > r^2 * |n|^2 on the outside
  function automatic verdict_t predict_cull(sphere_t sp);
    logic signed [WIDE-1:0] ctr [3];
    logic signed [WIDE-1:0] co [4];
    logic signed [WIDE-1:0] reach, nsq, rsq;
    plane_code_t            p;
    int                     axis;
    bit                     flip;
    verdict_t               v;
    ctr[0] = WIDE'($signed(sp.x));
    ctr[1] = WIDE'($signed(sp.y));
    ctr[2] = WIDE'($signed(sp.z));
    rsq = WIDE'(sp.r);
    rsq = rsq * rsq;
    v.all_in = 1'b1;
    v.plane = PL_NONE;
    for (int i = 0; i < NPLANE; i++) begin
      p = plane_code_t'(i);
      case (p)
        PL_LEFT: begin axis = 0; flip = 1'b0; end
        PL_RIGHT: begin axis = 0; flip = 1'b1; end
        PL_BOTTOM: begin axis = 1; flip = 1'b0; end
        PL_TOP: begin axis = 1; flip = 1'b1; end
        PL_NEAR: begin axis = 2; flip = 1'b0; end
        default: begin axis = 2; flip = 1'b1; end
      endcase
      for (int c = 0; c < 4; c++)
        co[c] = flip ? mat_word(c, 3) - mat_word(c, axis) : mat_word(c, 3) + mat_word(c, axis);
      reach = co[0] * ctr[0] + co[1] * ctr[1] + co[2] * ctr[2] + (co[3] <<< FRACTION_BITS);
      nsq = co[0] * co[0] + co[1] * co[1] + co[2] * co[2];
      if (v.all_in && nsq != 0 && reach < 0 && reach * reach > rsq * nsq) begin
        v.all_in = 1'b0;
        v.plane = p;
      end
    end
    return v;
  endfunction

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 13);
  endfunction

  function automatic sphere_t make_sphere(input logic signed [CTRW-1:0] x, y, z,
                                          input logic [RADW-1:0] r);
    sphere_t sp;
    sp.x = x;
    sp.y = y;
    sp.z = z;
    sp.r = r;
    return sp;
  endfunction

  function automatic logic signed [CTRW-1:0] extreme_coord();
    case ($urandom_range(4))
      0: return C_MIN;
      1: return C_MAX;
      2: return '0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  function automatic logic signed [CTRW-1:0] pick_coord(int lo, int hi);
    int unsigned k;
    k = $urandom_range(99);
    if (k < 8) return extreme_coord();
    if (k < 20) return $urandom;
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic sphere_t scene_sphere();
    sphere_t     sp;
    int unsigned k;
    sp.x = pick_coord(-48 * U, 48 * U);
    sp.y = pick_coord(-48 * U, 48 * U);
    sp.z = pick_coord(-160 * U, 16 * U);
    k = $urandom_range(99);
    if (k < 3) sp.r = '0;
    else if (k < 6) sp.r = R_MAX;
    else if (k < 8) sp.r = RADW'(1);
    else if (k < 20) sp.r = RADW'($urandom);
    else sp.r = RADW'($urandom_range(8 * U));
    return sp;
  endfunction

  function automatic logic [WORDW-1:0] extreme_word();
    case ($urandom_range(5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3: return '0;
      4: return 1;
      default: return U;
    endcase
  endfunction

  function automatic reg_set_t pack_grid(word_grid_t g);
    reg_set_t rs;
    for (int c = 0; c < 4; c++)
      for (int h = 0; h < 2; h++)
        rs[2*c + h] = {g[c][2*h + 1], g[c][2*h]};
    return rs;
  endfunction

  function automatic word_grid_t perspective();
    word_grid_t g;
    g = '{default: '0};
    g[0][0] = U;
    g[1][1] = U;
    g[2][2] = -(101 * U) / 99;
    g[3][2] = -(200 * U) / 99;
    g[2][3] = -U;
    return g;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    if (errors <= 40) $display("tb: mismatch on result %0d: %s", n_results, what);
  endtask

  task automatic load_matrix(reg_set_t rs);
    for (int i = 0; i < NREG; i++) begin
      @(negedge clk);
      cfg_write <= 1'b1;
      cfg_index <= IDXW'(i);
      cfg_data <= rs[i];
      mat_regs[i] = rs[i];
    end
    @(negedge clk);
    cfg_write <= 1'b0;
    n_settings++;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending.size() != 0 || in_valid || expected.size() != 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic run_scene(int n);
    repeat (n) pending.push_back(scene_sphere());
    wait_drained();
  endtask

  // driver: a new word goes out only after the previous one was taken
  always @(negedge clk) begin
    sphere_t next_word;
    if (!rst) begin
      if (!in_valid || in_took) begin
        if (pending.size() != 0 && !take_break()) begin
          next_word = pending.pop_front();
          in_valid <= 1'b1;
          centre_x <= next_word.x;
          centre_y <= next_word.y;
          centre_z <= next_word.z;
          sphere_radius <= next_word.r;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= take_break();
    end
    in_took = 1'b0;
  end

  // monitor and watchdog
  always @(posedge clk) begin
    sphere_t  got;
    verdict_t want;
    bit       moved;
    if (!rst) begin
      moved = cfg_write;
      if (in_valid && !in_stall) begin
        got = make_sphere(centre_x, centre_y, centre_z, sphere_radius);
        expected.push_back(predict_cull(got));
        in_took = 1'b1;
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        n_results++;
        if (expected.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = expected.pop_front();
          plane_hits[want.plane]++;
          if (inside_res !== want.all_in)
            report_mismatch($sformatf("inside_res %b, want %b", inside_res, want.all_in));
          if (culling_plane !== want.plane)
            report_mismatch($sformatf("culling_plane %0d, want %0d (%s)",
                                      culling_plane, want.plane, want.plane.name()));
        end
      end
      stuck = moved ? 0 : stuck + 1;
      if (stuck >= STUCK_LIMIT) begin
        $display("tb: no word moved for %0d cycles, %0d results pending",
                 STUCK_LIMIT, expected.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    word_grid_t grid;
    reg_set_t   rs;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // all-zero matrix: every normal is zero, nothing may be culled
    pending.push_back(make_sphere(C_MIN, C_MIN, C_MIN, R_MAX));
    pending.push_back(make_sphere(C_MAX, C_MAX, C_MAX, '0));
    pending.push_back(make_sphere('0, '0, '0, '0));
    pending.push_back(make_sphere(-U, '0, -U, '0));
    wait_drained();

    load_matrix(pack_grid(perspective()));
    pending.push_back(make_sphere('0, '0, -10 * U, RADW'(U)));
    pending.push_back(make_sphere(-20 * U, '0, -10 * U, RADW'(U)));
    pending.push_back(make_sphere(20 * U, '0, -10 * U, RADW'(U)));
    pending.push_back(make_sphere('0, -20 * U, -10 * U, RADW'(U)));
    pending.push_back(make_sphere('0, 20 * U, -10 * U, RADW'(U)));
    pending.push_back(make_sphere('0, '0, -U / 2, RADW'(U / 10)));
    pending.push_back(make_sphere('0, '0, -200 * U, RADW'(U)));
    pending.push_back(make_sphere('0, '0, 5 * U, RADW'(U)));
    pending.push_back(make_sphere(-20 * U, '0, -10 * U, RADW'(20 * U)));
    pending.push_back(make_sphere(-11 * U, '0, -10 * U, RADW'(U)));
    pending.push_back(make_sphere('0, '0, -10 * U, '0));
    pending.push_back(make_sphere(-11 * U, '0, -10 * U, '0));
    pending.push_back(make_sphere(C_MIN, '0, -10 * U, R_MAX));
    pending.push_back(make_sphere(C_MAX, C_MAX, C_MAX, R_MAX));
    pending.push_back(make_sphere(C_MIN, C_MIN, C_MIN, RADW'(1)));
    pending.push_back(make_sphere('0, '0, C_MIN, '0));
    pending.push_back(make_sphere(-1, 1, C_MAX, RADW'(1)));
    pending.push_back(make_sphere('0, C_MIN, '0, R_MAX));
    run_scene(300);

    calm = 1'b1;
    run_scene(300);
    calm = 1'b0;

    // only the constant column set: normals stay zero
    grid = '{default: '0};
    for (int r = 0; r < 4; r++) grid[3][r] = $urandom;
    load_matrix(pack_grid(grid));
    run_scene(150);

    repeat (3) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) grid[c][r] = extreme_word();
      load_matrix(pack_grid(grid));
      run_scene(100);
    end

    repeat (5) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) grid[c][r] = int'($urandom_range(4 * U)) - 2 * U;
      load_matrix(pack_grid(grid));
      run_scene(100);
    end

    repeat (4) begin
      for (int i = 0; i < NREG; i++) rs[i] = {$urandom, $urandom};
      load_matrix(rs);
      run_scene(100);
    end

    $display("tb: %0d spheres checked over %0d matrix settings, %0d inside",
             n_results, n_settings, plane_hits[PL_NONE]);
    $display("tb: first culls left %0d right %0d bottom %0d top %0d near %0d far %0d",
             plane_hits[PL_LEFT], plane_hits[PL_RIGHT], plane_hits[PL_BOTTOM],
             plane_hits[PL_TOP], plane_hits[PL_NEAR], plane_hits[PL_FAR]);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
